// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the modules that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition implies another one in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/ictf_pkg.sv -----
// Shared types, constants and helper functions of the tilt estimator.
`timescale 1ns / 1ps
package ictf_pkg;

    localparam int TS_W       = 48;
    localparam int DT_W       = 20;
    localparam int RATE_W     = 24;
    localparam int ANG_W      = 16;
    localparam int TAU_W      = 24;
    localparam int MAG_W      = 23;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    // Shared multiplier, serial divider, square root and CORDIC datapath widths.
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;
    localparam int NUM_W  = 44;
    localparam int QUO_W  = 22;
    localparam int DEN_W  = 25;
    localparam int CX_W   = 36;
    localparam int CZ_W   = 28;
    localparam int CNT_W  = 5;
    localparam int SQV_W  = 48;
    localparam int ROOT_W = 24;
    localparam int REM_W  = 27;

    localparam int CORDIC_STEPS = 16;
    localparam int QDEPTH  = 2;
    localparam int PTR_W   = 1;
    localparam int LEVEL_W = 2;

    localparam logic [TAU_W-1:0] TAU_RESET  = 24'd500000;
    localparam logic [DT_W-1:0]  MAXI_RESET = 20'd100000;
    localparam logic [MAG_W-1:0] MINM_RESET = 23'd321345;
    localparam logic [MAG_W-1:0] MAXM_RESET = 23'd964033;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_CONSTANT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_MIN     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_MAX     = 8'd3;

    // Q7.16 rad/s times microseconds into Q2.13 radians.
    localparam logic [DEN_W-1:0] GYRO_DIVISOR = 25'd8000000;
    localparam logic [NUM_W-1:0] GYRO_HALF    = 44'd4000000;

    localparam logic signed [CZ_W-1:0] HALF_PI_Z = 28'sd26353589;
    localparam logic signed [CZ_W-1:0] SAT_HI    = 28'sd32767;
    localparam logic signed [CZ_W-1:0] SAT_LO    = -28'sd32768;

    typedef struct packed {
        logic [TS_W-1:0]          sample_time_us;
        logic [1:0]               sensor_flags;
        logic signed [RATE_W-1:0] roll_rate;
        logic signed [RATE_W-1:0] pitch_rate;
        logic signed [RATE_W-1:0] accel_x;
        logic signed [RATE_W-1:0] accel_y;
        logic signed [RATE_W-1:0] accel_z;
    } t_in_item;

    typedef struct packed {
        logic signed [ANG_W-1:0] roll_angle;
        logic signed [ANG_W-1:0] pitch_angle;
        logic                    tilt_seeded;
    } t_out_item;

    typedef enum logic {
        OP_HOLD,
        OP_STEP
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic                     accel;
        logic [DT_W-1:0]          dt;
        logic signed [RATE_W-1:0] roll_rate;
        logic signed [RATE_W-1:0] pitch_rate;
        logic signed [RATE_W-1:0] accel_x;
        logic signed [RATE_W-1:0] accel_y;
        logic signed [RATE_W-1:0] accel_z;
    } t_q_entry;

    typedef struct packed {
        logic [TAU_W-1:0] time_constant_us;
        logic [DT_W-1:0]  max_interval_us;
        logic [MAG_W-1:0] accel_min_mag;
        logic [MAG_W-1:0] accel_max_mag;
    } t_cfg;

    typedef struct packed {
        logic               full;
        logic               nonempty;
        logic [LEVEL_W-1:0] level;
    } t_q_status;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_GMUL,
        BK_GDIV,
        BK_GWAIT,
        BK_SQ,
        BK_CHECK,
        BK_SQRT,
        BK_CINIT,
        BK_CORD,
        BK_CFIN,
        BK_BMUL,
        BK_BDIV,
        BK_BWAIT,
        BK_OUT
    } t_bk_state;

    function automatic logic signed [ANG_W-1:0] sat16(input logic signed [CZ_W-1:0] v);
        logic signed [ANG_W-1:0] r;
        if (v > SAT_HI) begin
            r = 16'sh7fff;
        end else if (v < SAT_LO) begin
            r = -16'sh8000;
        end else begin
            r = v[ANG_W-1:0];
        end
        return r;
    endfunction

    // Arctangent of 2^-i in units of 2^-24 rad.
    function automatic logic signed [CZ_W-1:0] atan_entry(input logic [CNT_W-1:0] i);
        logic signed [CZ_W-1:0] r;
        case (i)
            5'd0:    r = 28'sd13176795;
            5'd1:    r = 28'sd7778716;
            5'd2:    r = 28'sd4110060;
            5'd3:    r = 28'sd2086331;
            5'd4:    r = 28'sd1047214;
            5'd5:    r = 28'sd524117;
            5'd6:    r = 28'sd262123;
            5'd7:    r = 28'sd131069;
            5'd8:    r = 28'sd65536;
            5'd9:    r = 28'sd32768;
            5'd10:   r = 28'sd16384;
            5'd11:   r = 28'sd8192;
            5'd12:   r = 28'sd4096;
            5'd13:   r = 28'sd2048;
            5'd14:   r = 28'sd1024;
            5'd15:   r = 28'sd512;
            5'd16:   r = 28'sd256;
            5'd17:   r = 28'sd128;
            5'd18:   r = 28'sd64;
            5'd19:   r = 28'sd32;
            5'd20:   r = 28'sd16;
            5'd21:   r = 28'sd8;
            5'd22:   r = 28'sd4;
            5'd23:   r = 28'sd2;
            default: r = 28'sd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/imu_tilt_complementary_filter_top.sv -----
// Top level of the complementary roll and pitch tilt estimator.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Every accepted IMU sample produces exactly one output transaction carrying the
// current roll and pitch estimate in Q2.13 radians and the seeded flag. A sample
// without gyro data, or whose time stamp is not later than that of the previous
// gyro sample or lies more than max_interval_us after it, goes straight to the
// output state of the sequencer. A gyro step computes both gyro increments; if it
// carries accelerometer data, the magnitude is checked against the trusted band,
// and a trusted vector goes on to the square root and the CORDIC for both angles,
// which seed the estimate or are blended into it. The shared serial divider
// computes every quotient (two gyro increments, two blend corrections). The output
// register may also wait on a stalled receiver. A two-entry queue lets the input
// side take up to two more samples while the sequencer works, and the output
// register holds a finished transaction while the next sample is already being
// processed.
// Configuration registers are written through a plain write port and must only
// change while the block is idle.
module imu_tilt_complementary_filter_top import ictf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_q_entry  q_entry;
    t_q_entry  q_head;
    t_q_status q_stat;
    logic      q_push;
    logic      q_pop;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_constant_us <= TAU_RESET;
            r_cfg.max_interval_us  <= MAXI_RESET;
            r_cfg.accel_min_mag    <= MINM_RESET;
            r_cfg.accel_max_mag    <= MAXM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TIME_CONSTANT: r_cfg.time_constant_us <= i_cfg_data[TAU_W-1:0];
                REG_MAX_INTERVAL:  r_cfg.max_interval_us  <= i_cfg_data[DT_W-1:0];
                REG_ACCEL_MIN:     r_cfg.accel_min_mag    <= i_cfg_data[MAG_W-1:0];
                REG_ACCEL_MAX:     r_cfg.accel_max_mag    <= i_cfg_data[MAG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front end stamps each sample with its interval and decides whether
    // it moves the filter at all.
    ictf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .i_item         (i_in_data),
        .i_full         (q_stat.full),
        .i_max_interval (r_cfg.max_interval_us),
        .o_stall        (o_in_stall),
        .o_push         (q_push),
        .o_entry        (q_entry)
    );

    ictf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_entry  (q_entry),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_stat)
    );

    // The sequencer owns the estimate and the output register.
    ictf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head       (q_head),
        .i_head_valid (q_stat.nonempty),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

    // Once seeded, the estimate never loses its seed.
    `ASSERT_ALWAYS(a_seed_sticky, i_clk, i_rst_n, o_out_valid && o_out_data.tilt_seeded |=> !o_out_valid || o_out_data.tilt_seeded, "seeded flag dropped")
    // Before seeding the angles cannot move from zero.
    `ASSERT_IMPLIES(a_unseeded_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.tilt_seeded, o_out_data.roll_angle == 16'sd0 && o_out_data.pitch_angle == 16'sd0, "unseeded estimate is not zero")
    // The queue never holds more than its depth.
    `ASSERT_ALWAYS(a_queue_level, i_clk, i_rst_n, q_stat.level <= LEVEL_W'(QDEPTH), "queue overflow")

endmodule

// ----- rtl/ictf_div.sv -----
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ictf_div import ictf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quot
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   r_rem;
    logic [QUO_W-1:0] r_q;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   sh;
    logic [DEN_W+1:0] diff;
    logic             ge;

    // The callers guarantee the upper numerator bits stay below the divisor.
    assign sh   = {r_rem[DEN_W-1:0], r_q[QUO_W-1]};
    assign diff = {1'b0, sh} - {2'b00, r_den};
    assign ge   = !diff[DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(QUO_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= (DEN_W + 1)'(i_num[NUM_W-1:QUO_W]);
            r_q   <= i_num[QUO_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W:0] : sh;
            r_q   <= {r_q[QUO_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- rtl/ictf_front.sv -----
// Front end: accepts samples, measures the gyro interval and classifies them.
`timescale 1ns / 1ps
module ictf_front import ictf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  t_in_item        i_item,
    input  logic            i_full,
    input  logic [DT_W-1:0] i_max_interval,
    output logic            o_stall,
    output logic            o_push,
    output t_q_entry        o_entry
);

    logic [TS_W-1:0] r_last_time;
    logic [TS_W-1:0] diff;
    logic            gyro;
    logic            usable;

    assign gyro   = i_item.sensor_flags[0];
    assign diff   = i_item.sample_time_us - r_last_time;
    assign usable = (i_item.sample_time_us > r_last_time)
                    && (diff <= TS_W'(i_max_interval));

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
        end else if (o_push && gyro) begin
            r_last_time <= i_item.sample_time_us;
        end
    end

    always_comb begin
        o_entry.op         = (gyro && usable) ? OP_STEP : OP_HOLD;
        o_entry.accel      = i_item.sensor_flags[1];
        o_entry.dt         = diff[DT_W-1:0];
        o_entry.roll_rate  = i_item.roll_rate;
        o_entry.pitch_rate = i_item.pitch_rate;
        o_entry.accel_x    = i_item.accel_x;
        o_entry.accel_y    = i_item.accel_y;
        o_entry.accel_z    = i_item.accel_z;
    end

endmodule

// ----- rtl/ictf_queue.sv -----
// Two-entry queue between the front end and the filter sequencer.
`timescale 1ns / 1ps
module ictf_queue import ictf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_q_entry  i_entry,
    input  logic      i_pop,
    output t_q_entry  o_head,
    output t_q_status o_status
);

    t_q_entry           r_slot [QDEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [LEVEL_W-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (i_pop && !i_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_entry;
        end
    end

    assign o_head          = r_slot[r_rp];
    assign o_status.full     = (r_level == LEVEL_W'(QDEPTH));
    assign o_status.nonempty = (r_level != '0);
    assign o_status.level    = r_level;

endmodule

// ----- rtl/ictf_back.sv -----
// Filter sequencer: gyro prediction, gravity check, CORDIC tilt and blending.
`timescale 1ns / 1ps
module ictf_back import ictf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_q_entry  i_head,
    input  logic      i_head_valid,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_bk_state r_state, n_state;
    t_q_entry  r_item;
    logic      r_axis;
    logic [CNT_W-1:0] r_cnt;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_neg;

    logic signed [ANG_W-1:0] r_est_roll, r_est_pitch;
    logic                    r_est_valid;
    logic signed [ANG_W-1:0] r_pred_roll, r_pred_pitch;
    logic signed [ANG_W-1:0] r_acc_roll, r_acc_pitch;
    logic signed [ANG_W-1:0] r_res_roll, r_res_pitch;
    logic                    r_res_valid;

    logic [SQV_W:0]    r_mag;
    logic [SQV_W-1:0]  r_hsq;
    logic [2*MAG_W-1:0] r_lo2, r_hi2;

    logic [SQV_W-1:0]  r_sq_val;
    logic [REM_W-1:0]  r_sq_rem;
    logic [ROOT_W-1:0] r_root;

    logic signed [CX_W-1:0] r_cx, r_cy;
    logic signed [CZ_W-1:0] r_cz;
    logic                   r_czero;

    t_out_item r_out;
    logic      r_out_valid;

    // Shared datapath controls.
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic                    div_start;
    logic [NUM_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;
    logic                    div_done;
    logic [QUO_W-1:0]        div_quot;

    logic [PROD_W-1:0]       prod_abs;
    logic [DEN_W-1:0]        den_blend;
    logic signed [ANG_W:0]   diff_acc;
    logic                    out_free;
    logic                    last_cord;
    logic                    usable;

    logic signed [QUO_W:0]   q_signed;
    logic signed [ANG_W-1:0] est_axis, pred_axis, acc_axis;
    logic signed [ANG_W-1:0] pred_new, blend_new;

    logic [REM_W-1:0]        sq_sh, sq_trial;
    logic signed [MUL_W-1:0] c_x0, c_y0;
    logic signed [CX_W-1:0]  c_xs, c_ys, c_sx, c_sy;
    logic signed [CZ_W-1:0]  z_fin;
    logic [CZ_W-1:0]         z_abs;
    logic [CZ_W-1:0]         z_q;
    logic signed [CZ_W-1:0]  z_round;
    logic signed [ANG_W-1:0] acc_new;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign last_cord = (r_cnt == CNT_W'(CORDIC_STEPS - 1));
    assign usable    = (r_mag >= (SQV_W + 1)'(r_lo2)) && (r_mag <= (SQV_W + 1)'(r_hi2));
    assign prod_abs  = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign den_blend = DEN_W'(i_cfg.time_constant_us) + DEN_W'(r_item.dt);

    assign est_axis  = r_axis ? r_est_pitch : r_est_roll;
    assign pred_axis = r_axis ? r_pred_pitch : r_pred_roll;
    assign acc_axis  = r_axis ? r_acc_pitch : r_acc_roll;
    assign diff_acc  = (ANG_W + 1)'(acc_axis) - (ANG_W + 1)'(pred_axis);

    assign q_signed  = r_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    assign pred_new  = sat16(CZ_W'(est_axis) + CZ_W'(q_signed));
    assign blend_new = sat16(CZ_W'(pred_axis) + CZ_W'(q_signed));

    // Integer square root, one result bit per cycle.
    assign sq_sh    = {r_sq_rem[REM_W-3:0], r_sq_val[SQV_W-1:SQV_W-2]};
    assign sq_trial = {1'b0, r_root, 2'b01};

    // CORDIC start vector: roll from (az, ay), pitch from (h, -ax).
    assign c_x0 = r_axis ? $signed({1'b0, r_root}) : MUL_W'(r_item.accel_z);
    assign c_y0 = r_axis ? -MUL_W'(r_item.accel_x) : MUL_W'(r_item.accel_y);
    assign c_xs = CX_W'(c_x0) <<< 8;
    assign c_ys = CX_W'(c_y0) <<< 8;
    assign c_sx = r_cx >>> r_cnt;
    assign c_sy = r_cy >>> r_cnt;

    // Angle in 2^-24 rad to Q2.13, nearest with ties away from zero.
    assign z_fin   = r_czero ? '0 : r_cz;
    assign z_abs   = z_fin[CZ_W-1] ? CZ_W'(-z_fin) : CZ_W'(z_fin);
    assign z_q     = (z_abs + CZ_W'(1024)) >> 11;
    assign z_round = z_fin[CZ_W-1] ? -$signed(z_q) : $signed(z_q);
    assign acc_new = sat16(z_round);

    ictf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_head_valid) begin
                    n_state = (i_head.op == OP_STEP) ? BK_GMUL : BK_OUT;
                end
            end
            BK_GMUL:  n_state = BK_GDIV;
            BK_GDIV:  n_state = BK_GWAIT;
            BK_GWAIT: begin
                if (div_done) begin
                    if (!r_axis) begin
                        n_state = BK_GMUL;
                    end else begin
                        n_state = r_item.accel ? BK_SQ : BK_OUT;
                    end
                end
            end
            BK_SQ: begin
                if (r_cnt == CNT_W'(5)) begin
                    n_state = BK_CHECK;
                end
            end
            BK_CHECK: n_state = usable ? BK_SQRT : BK_OUT;
            BK_SQRT: begin
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    n_state = BK_CINIT;
                end
            end
            BK_CINIT: n_state = BK_CORD;
            BK_CORD: begin
                if (last_cord) begin
                    n_state = BK_CFIN;
                end
            end
            BK_CFIN: begin
                if (!r_axis) begin
                    n_state = BK_CINIT;
                end else begin
                    n_state = r_est_valid ? BK_BMUL : BK_OUT;
                end
            end
            BK_BMUL:  n_state = BK_BDIV;
            BK_BDIV:  n_state = BK_BWAIT;
            BK_BWAIT: begin
                if (div_done) begin
                    n_state = r_axis ? BK_OUT : BK_BMUL;
                end
            end
            BK_OUT: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        div_start = 1'b0;
        div_num   = prod_abs[NUM_W-1:0] + GYRO_HALF;
        div_den   = GYRO_DIVISOR;
        mul_a     = MUL_W'(r_axis ? r_item.pitch_rate : r_item.roll_rate);
        mul_b     = $signed(MUL_W'(r_item.dt));
        unique case (r_state)
            BK_IDLE: o_pop = i_head_valid;
            BK_GDIV: div_start = 1'b1;
            BK_SQ: begin
                case (r_cnt)
                    5'd0:    begin mul_a = MUL_W'(r_item.accel_x); mul_b = mul_a; end
                    5'd1:    begin mul_a = MUL_W'(r_item.accel_y); mul_b = mul_a; end
                    5'd2:    begin mul_a = MUL_W'(r_item.accel_z); mul_b = mul_a; end
                    5'd3:    begin
                        mul_a = $signed(MUL_W'(i_cfg.accel_min_mag)); mul_b = mul_a;
                    end
                    default: begin
                        mul_a = $signed(MUL_W'(i_cfg.accel_max_mag)); mul_b = mul_a;
                    end
                endcase
            end
            BK_BMUL: mul_a = MUL_W'(diff_acc);
            BK_BDIV: begin
                div_start = 1'b1;
                div_num   = prod_abs[NUM_W-1:0] + NUM_W'(den_blend >> 1);
                div_den   = den_blend;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_est_roll  <= '0;
            r_est_pitch <= '0;
            r_est_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_OUT && out_free) begin
                r_est_roll  <= r_res_roll;
                r_est_pitch <= r_res_pitch;
                r_est_valid <= r_res_valid;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_cnt  <= (n_state != r_state) ? '0 : r_cnt + 1'b1;
        case (r_state)
            BK_IDLE: begin
                r_item      <= i_head;
                r_axis      <= 1'b0;
                r_res_roll  <= r_est_roll;
                r_res_pitch <= r_est_pitch;
                r_res_valid <= r_est_valid;
            end
            BK_GDIV:  r_neg <= r_prod[PROD_W-1];
            BK_GWAIT: begin
                if (div_done) begin
                    r_axis <= !r_axis;
                    if (!r_axis) begin
                        r_pred_roll <= pred_new;
                    end else begin
                        r_pred_pitch <= pred_new;
                        if (r_est_valid) begin
                            r_res_roll  <= r_pred_roll;
                            r_res_pitch <= pred_new;
                        end
                    end
                end
            end
            BK_SQ: begin
                case (r_cnt)
                    5'd1: r_mag <= (SQV_W + 1)'(r_prod[SQV_W-1:0]);
                    5'd2: begin
                        r_mag <= r_mag + (SQV_W + 1)'(r_prod[SQV_W-1:0]);
                        r_hsq <= r_prod[SQV_W-1:0];
                    end
                    5'd3: begin
                        r_mag <= r_mag + (SQV_W + 1)'(r_prod[SQV_W-1:0]);
                        r_hsq <= r_hsq + r_prod[SQV_W-1:0];
                    end
                    5'd4: r_lo2 <= r_prod[2*MAG_W-1:0];
                    5'd5: r_hi2 <= r_prod[2*MAG_W-1:0];
                    default: begin
                    end
                endcase
            end
            BK_CHECK: begin
                r_sq_val <= r_hsq;
                r_sq_rem <= '0;
                r_root   <= '0;
            end
            BK_SQRT: begin
                r_sq_val <= r_sq_val << 2;
                if (sq_sh >= sq_trial) begin
                    r_sq_rem <= sq_sh - sq_trial;
                    r_root   <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_sq_rem <= sq_sh;
                    r_root   <= {r_root[ROOT_W-2:0], 1'b0};
                end
            end
            BK_CINIT: begin
                r_czero <= (c_x0 == '0) && (c_y0 == '0);
                if (c_xs[CX_W-1]) begin
                    if (!c_ys[CX_W-1]) begin
                        r_cx <= c_ys;
                        r_cy <= -c_xs;
                        r_cz <= HALF_PI_Z;
                    end else begin
                        r_cx <= -c_ys;
                        r_cy <= c_xs;
                        r_cz <= -HALF_PI_Z;
                    end
                end else begin
                    r_cx <= c_xs;
                    r_cy <= c_ys;
                    r_cz <= '0;
                end
            end
            BK_CORD: begin
                if (!r_cy[CX_W-1]) begin
                    r_cx <= r_cx + c_sy;
                    r_cy <= r_cy - c_sx;
                    r_cz <= r_cz + atan_entry(r_cnt);
                end else begin
                    r_cx <= r_cx - c_sy;
                    r_cy <= r_cy + c_sx;
                    r_cz <= r_cz - atan_entry(r_cnt);
                end
            end
            BK_CFIN: begin
                r_axis <= !r_axis;
                if (!r_axis) begin
                    r_acc_roll <= acc_new;
                end else begin
                    r_acc_pitch <= acc_new;
                    if (!r_est_valid) begin
                        r_res_roll  <= r_acc_roll;
                        r_res_pitch <= acc_new;
                        r_res_valid <= 1'b1;
                    end
                end
            end
            BK_BDIV: r_neg <= r_prod[PROD_W-1];
            BK_BWAIT: begin
                if (div_done) begin
                    r_axis <= !r_axis;
                    if (!r_axis) begin
                        r_res_roll <= blend_new;
                    end else begin
                        r_res_pitch <= blend_new;
                    end
                end
            end
            BK_OUT: begin
                if (out_free) begin
                    r_out.roll_angle  <= r_res_roll;
                    r_out.pitch_angle <= r_res_pitch;
                    r_out.tilt_seeded <= r_res_valid;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench of the complementary roll and pitch tilt estimator.
`timescale 1ns / 1ps
module tb;
    import ictf_pkg::*;

    // Tilt estimator predictor and the queue of estimates it expects.
    class tilt_scoreboard;
        logic [23:0] tau;
        logic [19:0] max_dt;
        logic [22:0] min_mag;
        logic [22:0] max_mag;
        logic [47:0] last_ts;
        longint roll_est;
        longint pitch_est;
        bit seeded;
        t_out_item expected_q[$];
        int errors;

        function new();
            tau = TAU_RESET;
            max_dt = MAXI_RESET;
            min_mag = MINM_RESET;
            max_mag = MAXM_RESET;
            last_ts = '0;
            roll_est = 0;
            pitch_est = 0;
            seeded = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_TIME_CONSTANT: tau = val[23:0];
                REG_MAX_INTERVAL:  max_dt = val[19:0];
                REG_ACCEL_MIN:     min_mag = val[22:0];
                REG_ACCEL_MAX:     max_mag = val[22:0];
                default: ;
            endcase
        endfunction

        function longint clamp16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        // Division rounded to nearest with ties away from zero.
        function longint div_round(longint n, longint d);
            longint a;
            longint q;
            a = (n < 0) ? -n : n;
            q = (a + d / 2) / d;
            return (n < 0) ? -q : q;
        endfunction

        function longint shift_floor(longint v, int s);
            return v >>> s;
        endfunction

        function longint int_sqrt(longint v);
            longint r;
            longint b;
            r = 0;
            b = 64'sd1 <<< 62;
            while (b > v) b = b >>> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - r - b;
                    r = (r >>> 1) + b;
                end else begin
                    r = r >>> 1;
                end
                b = b >>> 2;
            end
            return r;
        endfunction

        // Vectoring CORDIC arctangent, angle in 2^-24 rad, rounded to Q2.13.
        function longint vector_angle(longint y, longint x);
            longint z;
            longint t;
            longint nx;
            longint ny;
            z = 0;
            if (x == 0 && y == 0) return 0;
            x = x * 256;
            y = y * 256;
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; z = HALF_PI_Z;
                end else begin
                    t = x; x = -y; y = t; z = -HALF_PI_Z;
                end
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (y >= 0) begin
                    nx = x + shift_floor(y, i);
                    ny = y - shift_floor(x, i);
                    z = z + atan_entry(i[CNT_W-1:0]);
                end else begin
                    nx = x - shift_floor(y, i);
                    ny = y + shift_floor(x, i);
                    z = z - atan_entry(i[CNT_W-1:0]);
                end
                x = nx;
                y = ny;
            end
            return clamp16(div_round(z, 2048));
        endfunction

        function void note_sample(t_in_item s);
            logic [47:0] prev;
            longint dt;
            longint roll_guess;
            longint pitch_guess;
            longint ax;
            longint ay;
            longint az;
            longint mag2;
            longint roll_grav;
            longint pitch_grav;
            longint den;
            bit trusted;
            t_out_item e;
            if (s.sensor_flags[0]) begin
                prev = last_ts;
                last_ts = s.sample_time_us;
                if (s.sample_time_us > prev && (s.sample_time_us - prev) <= {28'd0, max_dt}) begin
                    dt = longint'(s.sample_time_us - prev);
                    roll_guess = clamp16(roll_est
                        + div_round(longint'(s.roll_rate) * dt, 8000000));
                    pitch_guess = clamp16(pitch_est
                        + div_round(longint'(s.pitch_rate) * dt, 8000000));
                    trusted = 0;
                    ax = s.accel_x;
                    ay = s.accel_y;
                    az = s.accel_z;
                    if (s.sensor_flags[1]) begin
                        mag2 = ax * ax + ay * ay + az * az;
                        trusted = mag2 >= longint'(min_mag) * longint'(min_mag)
                            && mag2 <= longint'(max_mag) * longint'(max_mag);
                    end
                    if (!trusted) begin
                        if (seeded) begin
                            roll_est = roll_guess;
                            pitch_est = pitch_guess;
                        end
                    end else begin
                        roll_grav = vector_angle(ay, az);
                        pitch_grav = vector_angle(-ax, int_sqrt(ay * ay + az * az));
                        if (!seeded) begin
                            roll_est = roll_grav;
                            pitch_est = pitch_grav;
                            seeded = 1;
                        end else begin
                            den = longint'(tau) + dt;
                            roll_est = clamp16(roll_guess
                                + div_round((roll_grav - roll_guess) * dt, den));
                            pitch_est = clamp16(pitch_guess
                                + div_round((pitch_grav - pitch_guess) * dt, den));
                        end
                    end
                end
            end
            e.roll_angle = roll_est[15:0];
            e.pitch_angle = pitch_est[15:0];
            e.tilt_seeded = seeded;
            expected_q.push_back(e);
        endfunction

        function void check_estimate(t_out_item got);
            t_out_item e;
            if (expected_q.size() == 0) begin
                $error("unexpected output transaction %p", got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.roll_angle !== e.roll_angle) begin
                $error("roll_angle expected %0d actual %0d", e.roll_angle, got.roll_angle);
                errors++;
            end
            if (got.pitch_angle !== e.pitch_angle) begin
                $error("pitch_angle expected %0d actual %0d", e.pitch_angle, got.pitch_angle);
                errors++;
            end
            if (got.tilt_seeded !== e.tilt_seeded) begin
                $error("tilt_seeded expected %0d actual %0d", e.tilt_seeded, got.tilt_seeded);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_OFF_CYCLES = 2000;

    // Register indexes that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_LO = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_HI = 8'hff;

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_in_valid = 0;
    logic                  o_in_stall;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 0;
    t_out_item             o_out_data;
    logic                  i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    imu_tilt_complementary_filter_top dut (.*);

    always #6 i_clk = ~i_clk;

    tilt_scoreboard sb = new();
    int cycles = 0;
    bit idle_on = 1;       // random gaps on both sides
    bit hold_off = 0;      // request for a long receiver stall
    logic [47:0] now_us = 48'd1000;

    // Every accepted input transaction goes to the predictor, every output
    // transaction is checked against the oldest expected estimate.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_sample(i_in_data);
            if (o_out_valid && !i_out_stall) sb.check_estimate(o_out_data);
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stalls, and on request one long stretch held off.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off = 0;
            end
            i_out_stall <= idle_on && ($urandom_range(99) < 33);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, val);
    endtask

    // Offers one sample; the valid stays high until a rising edge accepts it.
    // The task returns at the falling edge after acceptance, and the next call
    // or the drain decides the valid there.
    task automatic send_sample(t_in_item s);
        while (idle_on && $urandom_range(99) < 33) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_in_data <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Waits until every estimate has come back and the block has gone quiet.
    task automatic drain();
        i_in_valid <= 0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    function automatic logic [23:0] rand24();
        case ($urandom_range(5))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2: return 24'(int'($urandom_range(1310720)) - 655360);
            default: return 24'($urandom());
        endcase
    endfunction

    // Gravity of about 1 g pointing in a random direction, sometimes scaled off band.
    function automatic t_in_item gravity_sample(logic [47:0] ts, logic [1:0] flags);
        t_in_item s;
        int g;
        s.sample_time_us = ts;
        s.sensor_flags = flags;
        s.roll_rate = 24'(int'($urandom_range(400000)) - 200000);
        s.pitch_rate = 24'(int'($urandom_range(400000)) - 200000);
        g = ($urandom_range(9) == 0) ? 2000000 : 642689;
        s.accel_x = 24'((int'($urandom_range(2 * g)) - g) / 2);
        s.accel_y = 24'((int'($urandom_range(2 * g)) - g) / 2);
        s.accel_z = 24'(int'($urandom_range(2 * g)) - g);
        return s;
    endfunction

    task automatic directed_part();
        t_in_item s;
        s = gravity_sample(48'd0, 2'b01);
        send_sample(s);                              // no interval since reset
        s.sensor_flags = 2'b10;
        send_sample(s);                              // no gyro data
        s = gravity_sample(48'd1000, 2'b01);
        send_sample(s);                              // gyro only, unseeded
        s = gravity_sample(48'd2000, 2'b11);
        s.accel_x = '0; s.accel_y = '0; s.accel_z = 24'sd642689;
        send_sample(s);                              // seed, level
        s = gravity_sample(48'd2000, 2'b11);
        send_sample(s);                              // time not advancing
        s = gravity_sample(48'd1500, 2'b11);
        send_sample(s);                              // time going backward
        s = gravity_sample(48'd500000, 2'b11);
        send_sample(s);                              // interval too long
        s = gravity_sample(48'd600000, 2'b01);
        s.roll_rate = 24'h7fffff; s.pitch_rate = 24'h800000;
        send_sample(s);                              // extreme rates, saturation
        s.sample_time_us = 48'd700000;
        send_sample(s);
        s = gravity_sample(48'd700001, 2'b11);
        s.accel_x = '0; s.accel_y = '0; s.accel_z = 24'h800000;
        send_sample(s);                              // gravity upside down
        s.sample_time_us = 48'd700002; s.accel_y = 24'h7fffff; s.accel_z = '0;
        s.accel_x = 24'h800000;
        send_sample(s);                              // extreme accel, off band
        s.sample_time_us = 48'd700003; s.accel_x = 24'sd642689; s.accel_y = '0;
        send_sample(s);                              // nose down
        s = gravity_sample(48'hffff_ffff_fff0, 2'b11);
        send_sample(s);                              // time near wrap, too long
        s.sample_time_us = 48'hffff_ffff_ffff;
        send_sample(s);
        s.sample_time_us = 48'd5;
        send_sample(s);                              // backward after the top
        drain();
    endtask

    task automatic random_phase(int count, bit mostly_valid_dt);
        t_in_item s;
        logic [47:0] step;
        for (int n = 0; n < count; n++) begin
            if (mostly_valid_dt && $urandom_range(9) != 0)
                step = 48'($urandom_range(1, 3000));
            else
                step = 48'({$urandom(), $urandom()} >> $urandom_range(47));
            if ($urandom_range(19) == 0) step = '0;
            now_us = now_us + step;
            s = gravity_sample(now_us, 2'($urandom_range(3)));
            if ($urandom_range(7) == 0) begin
                s.roll_rate = rand24();
                s.pitch_rate = rand24();
                s.accel_x = rand24();
                s.accel_y = rand24();
                s.accel_z = rand24();
            end
            if ($urandom_range(3) == 0) s.sample_time_us = 48'({$urandom(), $urandom()});
            if (s.sample_time_us != now_us && $urandom_range(1)) now_us = s.sample_time_us;
            send_sample(s);
        end
        drain();
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        directed_part();

        // Zero band floor lets a zero gravity vector through.
        write_reg(REG_ACCEL_MIN, '0);
        write_reg(REG_TIME_CONSTANT, '0);
        send_sample('{sample_time_us: now_us + 10, sensor_flags: 2'b11, default: '0});
        now_us = now_us + 10;
        send_sample('{sample_time_us: now_us + 10, sensor_flags: 2'b11, default: '0});
        now_us = now_us + 10;
        drain();
        random_phase(200, 1);

        // Largest time constant, interval and band ceiling; random gaps and stalls off and one long hold-off.
        write_reg(REG_TIME_CONSTANT, 24'hffffff);
        write_reg(REG_MAX_INTERVAL, 24'h0fffff);
        write_reg(REG_ACCEL_MAX, 24'h7fffff);
        write_reg(REG_ACCEL_MIN, 24'd1);
        idle_on = 0;
        hold_off = 1;
        random_phase(250, 1);
        idle_on = 1;

        // Smallest settings, an inverted band and unknown register indexes.
        write_reg(REG_TIME_CONSTANT, 24'd1);
        write_reg(REG_MAX_INTERVAL, 24'd1);
        write_reg(REG_ACCEL_MIN, 24'h7fffff);
        write_reg(REG_ACCEL_MAX, '0);
        write_reg(REG_UNKNOWN_LO, 24'h123456);
        write_reg(REG_UNKNOWN_HI, 24'hffffff);
        random_phase(150, 0);

        write_reg(REG_MAX_INTERVAL, '0);
        random_phase(50, 1);

        // Back to the usual band with a short time constant, then a long one.
        write_reg(REG_TIME_CONSTANT, 24'd20000);
        write_reg(REG_MAX_INTERVAL, 24'd100000);
        write_reg(REG_ACCEL_MIN, 24'd321345);
        write_reg(REG_ACCEL_MAX, 24'd964033);
        random_phase(600, 1);
        write_reg(REG_TIME_CONSTANT, 24'd10000000);
        random_phase(480, 1);

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ----- imu_tilt_complementary_filter_top.f -----
+incdir+rtl
rtl/ictf_pkg.sv
rtl/ictf_div.sv
rtl/ictf_front.sv
rtl/ictf_queue.sv
rtl/ictf_back.sv
rtl/imu_tilt_complementary_filter_top.sv
dv/tb.sv
